[rtl/sct_pkg.sv]
package sct_pkg;

    // Default sizes of the store and of the fields.
    localparam int unsigned DEF_MAX_ENTRIES = 256;
    localparam int unsigned DEF_INDEX_BITS  = 16;
    localparam int unsigned DEF_VALUE_BITS  = 64;

    // Command codes on the input channel.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_DRAIN_BUSY = 2'd3
    } t_status;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;
        logic drain;
    } t_cell_ctrl;

endpackage

[rtl/sct_cell.sv]
module sct_cell #(
    parameter int unsigned KEY_BITS   = 2 * sct_pkg::DEF_INDEX_BITS,
    parameter int unsigned VALUE_BITS = sct_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  sct_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_occupied,
    input  logic                  i_left_greater,
    input  logic [KEY_BITS-1:0]   i_left_key,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [KEY_BITS-1:0]   i_right_key,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic [KEY_BITS-1:0]   i_new_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_greater
);
    import sct_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [KEY_BITS-1:0]   n_key;
    logic [VALUE_BITS-1:0] n_value;

    // A stored key equal to the new one stays ahead of it, which keeps the order stable.
    assign o_greater = i_occupied && (r_key > i_new_key);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctrl.drain) begin
            n_key   = i_right_key;
            n_value = i_right_value;
        end else if (i_ctrl.load) begin
            if (i_left_greater) begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end else if (o_greater || !i_occupied) begin
                n_key   = i_new_key;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

[rtl/sparse_coo_transpose_sorter_core.sv]
// Transposing sorter for sparse matrices held in coordinate form.
// The input channel (i_in_valid / o_in_stall) carries commands. A load brings one
// source entry, which is stored with row and column swapped, in order of new row
// then new column; entries with equal keys keep their arrival order. A drain
// returns the entry at the head of the order and flags the final one with
// o_out_last, after which the store is empty and takes loads again.
// The output channel (o_out_valid / i_out_stall) returns one result per command:
// a status, and for a successful drain the transposed entry.
// The result of an accepted command is registered in the following cycle, and a
// new command is taken in every cycle that o_in_stall is low: the store is a
// chain of cells that all compare their key with the incoming one in the same
// cycle and shift one place; one key compare per cell, independent of fill.
// While the receiver stalls a waiting result, o_in_stall is raised and the
// result holds; once it is taken the next command flows again without a bubble.
// Reset (i_rst_n low, synchronous) empties the store, ends any drain and drops
// a waiting result; no clearing pass is needed, the store is ready at once.
module sparse_coo_transpose_sorter_core #(
    parameter int unsigned MAX_ENTRIES = sct_pkg::DEF_MAX_ENTRIES,
    parameter int unsigned INDEX_BITS  = sct_pkg::DEF_INDEX_BITS,
    parameter int unsigned VALUE_BITS  = sct_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [INDEX_BITS-1:0] i_entry_row,
    input  logic [INDEX_BITS-1:0] i_entry_col,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sct_pkg::t_status      o_status,
    output logic [INDEX_BITS-1:0] o_out_row,
    output logic [INDEX_BITS-1:0] o_out_col,
    output logic [VALUE_BITS-1:0] o_out_value,
    output logic                  o_out_last
);
    import sct_pkg::*;

    localparam int unsigned KEY_BITS = 2 * INDEX_BITS;
    localparam int unsigned CW       = $clog2(MAX_ENTRIES + 1);

    // Control state: fill level and whether a drain batch is under way.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_draining;
    logic          n_draining;

    // Result register.
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [INDEX_BITS-1:0] r_out_row;
    logic [INDEX_BITS-1:0] n_out_row;
    logic [INDEX_BITS-1:0] r_out_col;
    logic [INDEX_BITS-1:0] n_out_col;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [VALUE_BITS-1:0] n_out_value;
    logic                  r_out_last;
    logic                  n_out_last;

    logic          in_fire;
    logic          out_fire;
    logic          is_load;
    logic          store_full;
    logic          store_empty;
    t_cell_ctrl    cell_ctrl;
    logic [KEY_BITS-1:0] new_key;

    logic [KEY_BITS-1:0]   cell_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_greater;

    // The result register frees itself in the same cycle that it is taken.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_fire   = r_out_valid && !i_out_stall;

    assign is_load     = (i_command == CMD_LOAD);
    assign store_full  = (r_count == CW'(MAX_ENTRIES));
    assign store_empty = (r_count == '0);

    // The transposed key: new row (the source column) in the upper half.
    assign new_key = {i_entry_col, i_entry_row};

    always_comb begin
        cell_ctrl.load  = in_fire && is_load && !r_draining && !store_full;
        cell_ctrl.drain = in_fire && !is_load && !store_empty;
    end

    // The chain: cell 0 holds the head of the order, each cell takes its left
    // neighbour's entry on an insertion before it and its right neighbour's on a drain.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic                  left_greater;
        logic [KEY_BITS-1:0]   left_key;
        logic [VALUE_BITS-1:0] left_value;
        logic [KEY_BITS-1:0]   right_key;
        logic [VALUE_BITS-1:0] right_value;
        logic                  occupied;

        assign occupied = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_greater = 1'b0;
            assign left_key     = new_key;
            assign left_value   = i_entry_value;
        end else begin : g_body
            assign left_greater = cell_greater[g-1];
            assign left_key     = cell_key[g-1];
            assign left_value   = cell_value[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign right_key   = '0;
            assign right_value = '0;
        end else begin : g_inner
            assign right_key   = cell_key[g+1];
            assign right_value = cell_value[g+1];
        end

        sct_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (cell_ctrl),
            .i_occupied     (occupied),
            .i_left_greater (left_greater),
            .i_left_key     (left_key),
            .i_left_value   (left_value),
            .i_right_key    (right_key),
            .i_right_value  (right_value),
            .i_new_key      (new_key),
            .i_new_value    (i_entry_value),
            .o_key          (cell_key[g]),
            .o_value        (cell_value[g]),
            .o_greater      (cell_greater[g])
        );
    end

    // Command decode and the next result.
    always_comb begin
        n_count     = r_count;
        n_draining  = r_draining;
        n_status    = r_status;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;

        if (out_fire) begin
            n_out_valid = 1'b0;
        end

        if (in_fire) begin
            n_out_valid = 1'b1;
            n_out_row   = '0;
            n_out_col   = '0;
            n_out_value = '0;
            n_out_last  = 1'b0;
            if (is_load) begin
                if (r_draining) begin
                    n_status = ST_DRAIN_BUSY;
                end else if (store_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + 1'b1;
                end
            end else if (store_empty) begin
                // Nothing stored: the batch state is already idle.
                n_status   = ST_EMPTY;
                n_draining = 1'b0;
            end else begin
                n_status    = ST_OK;
                n_out_row   = cell_key[0][KEY_BITS-1:INDEX_BITS];
                n_out_col   = cell_key[0][INDEX_BITS-1:0];
                n_out_value = cell_value[0];
                n_count     = r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    n_out_last = 1'b1;
                    n_draining = 1'b0;
                end else begin
                    n_draining = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_draining  <= n_draining;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

[rtl/sct_checker.sv]
module sct_checker #(
    parameter int unsigned INDEX_BITS = sct_pkg::DEF_INDEX_BITS,
    parameter int unsigned VALUE_BITS = sct_pkg::DEF_VALUE_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input sct_pkg::t_status      o_status,
    input logic [INDEX_BITS-1:0] o_out_row,
    input logic [INDEX_BITS-1:0] o_out_col,
    input logic [VALUE_BITS-1:0] o_out_value,
    input logic                  o_out_last
);
    import sct_pkg::*;

    // The input side is only held off by a result that waits.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // Every accepted command leaves a result in the following cycle.
    a_input_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted command gave no result");

    // The final entry of a batch is always a successful drain.
    a_last_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_last) |-> (o_status == ST_OK))
        else $error("final-entry mark on a failed command");

    // A failed command carries no entry.
    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_out_row == '0 && o_out_col == '0 && o_out_value == '0 && !o_out_last))
        else $error("failed command returned entry fields");

    // A stalled result holds.
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_out_row)
             && $stable(o_out_col) && $stable(o_out_value) && $stable(o_out_last)))
        else $error("stalled result changed");

endmodule

bind sparse_coo_transpose_sorter_core sct_checker #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_sct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_value (o_out_value),
    .o_out_last  (o_out_last)
);
